/* rtl/hum_pkg.sv */
package hum_pkg;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_REPORT = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_SPARE  = 2'd3
  } func_t;

  localparam int WORD_W = 32;
  localparam int PCT_W  = 7;
  // (a - b) * 100 fits in 39 bits
  localparam int PROD_W = WORD_W + PCT_W;

  localparam logic [PROD_W-1:0] PCT_SCALE = PROD_W'(100);

  localparam int ITER_W = 6;
  localparam logic [ITER_W-1:0] DIV_PCT_ITERS = ITER_W'(PCT_W);
  localparam logic [ITER_W-1:0] DIV_AVG_ITERS = ITER_W'(WORD_W);

  typedef struct packed {
    logic [1:0]        func;
    logic [WORD_W-1:0] free_bytes;
    logic [WORD_W-1:0] total_bytes;
    logic [WORD_W-1:0] largest_block;
  } in_t;

  typedef struct packed {
    logic [PCT_W-1:0]  usage_percent;
    logic [PCT_W-1:0]  frag_percent;
    logic              summary_valid;
    logic [WORD_W-1:0] mean_free;
    logic [WORD_W-1:0] low_free;
    logic [WORD_W-1:0] peak_free;
    logic              leak_suspect;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
    logic [WORD_W-1:0] rem_init;
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/hum_cell.sv */
module hum_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [hum_pkg::WORD_W-1:0] d,
  output logic [hum_pkg::WORD_W-1:0] q
);

  logic [hum_pkg::WORD_W-1:0] val_r;

  // one history slot, takes its neighbor's word on every shift
  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= d;
    end
  end

  assign q = val_r;

endmodule

/* rtl/hum_div.sv */
module hum_div (
  input  logic              clk,
  input  logic              rst_n,
  input  hum_pkg::div_req_t req,
  output hum_pkg::div_rsp_t rsp
);

  logic                        busy_r;
  logic                        done_r;
  logic [hum_pkg::ITER_W-1:0]  cnt_r;
  logic [hum_pkg::WORD_W-1:0]  rem_r;
  logic [hum_pkg::WORD_W-1:0]  low_r;
  logic [hum_pkg::WORD_W-1:0]  quo_r;
  logic [hum_pkg::WORD_W-1:0]  dvs_r;
  logic [hum_pkg::WORD_W+1:0]  trial;
  logic                        q_bit;

  // restoring step: bring down the next dividend bit, try a subtract
  assign trial = {1'b0, rem_r, low_r[hum_pkg::WORD_W-1]} - {2'b00, dvs_r};
  assign q_bit = ~trial[hum_pkg::WORD_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - hum_pkg::ITER_W'(1);
        if (cnt_r == hum_pkg::ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem_init;
      low_r <= req.low;
      dvs_r <= req.divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= q_bit ? trial[hum_pkg::WORD_W-1:0]
                     : {rem_r[hum_pkg::WORD_W-2:0], low_r[hum_pkg::WORD_W-1]};
      low_r <= {low_r[hum_pkg::WORD_W-2:0], 1'b0};
      quo_r <= {quo_r[hum_pkg::WORD_W-2:0], q_bit};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

/* rtl/heap_usage_window_monitor_top.sv */
// from input word to result word: history scan over all HISTORY_DEPTH cells, then the
// shared bit-serial divider for usage, fragmentation and the average (each division may be
// skipped), then the output register is loaded. one word in flight; next word taken the cycle
// after the result is loaded.
// reset clears sample count and control; history cells keep stale contents, unused
module heap_usage_window_monitor_top #(
  parameter int HISTORY_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hum_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output hum_pkg::out_t out_data
);

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = hum_pkg::WORD_W + CNT_W;
  localparam int W     = hum_pkg::WORD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_USE,
    S_FRAG,
    S_AVG,
    S_DONE
  } state_t;

  state_t                     state_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [CNT_W-1:0]           scan_r;
  logic                       go_r;
  logic                       out_valid_r;
  hum_pkg::out_t              out_r;
  hum_pkg::in_t               in_r;
  logic [SUM_W-1:0]           sum_r;
  logic [W-1:0]               min_r;
  logic [W-1:0]               max_r;
  logic [hum_pkg::PROD_W-1:0] prod_u_r;
  logic [hum_pkg::PROD_W-1:0] prod_f_r;
  logic [hum_pkg::PCT_W-1:0]  use_q_r;
  logic [hum_pkg::PCT_W-1:0]  frag_q_r;
  logic [W-1:0]               avg_r;

  logic                       accept;
  logic                       shift_en;
  logic [W-1:0]               head_d;
  logic [W-1:0]               tail;
  logic [W-1:0]               cell_q [HISTORY_DEPTH];
  logic                       incl;
  logic                       scan_last;
  logic                       use_skip;
  logic                       frag_skip;
  logic                       hist_any;
  logic [W+2:0]               leak_lhs;
  logic [W+2:0]               leak_rhs;
  hum_pkg::div_req_t          div_req;
  hum_pkg::div_rsp_t          div_rsp;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // newest sample enters cell 0; during the scan the row rotates once
  assign tail     = cell_q[HISTORY_DEPTH-1];
  assign head_d   = (state_r == S_IDLE) ? in_data.free_bytes : tail;
  assign shift_en = (accept && in_data.func == hum_pkg::FUNC_RECORD) || (state_r == S_SCAN);

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      hum_cell u_cell (.clk(clk), .en(shift_en), .d(head_d), .q(cell_q[i]));
    end else begin : g_body
      hum_cell u_cell (.clk(clk), .en(shift_en), .d(cell_q[i-1]), .q(cell_q[i]));
    end
  end

  // at scan step j the tail holds cell DEPTH-1-j; live cells are below cnt_r
  assign incl = ({1'b0, scan_r} + {1'b0, cnt_r}) >= (CNT_W + 1)'(HISTORY_DEPTH);
  assign scan_last = (scan_r == CNT_W'(HISTORY_DEPTH - 1));

  assign use_skip  = (in_r.total_bytes == '0) || (in_r.free_bytes > in_r.total_bytes);
  assign frag_skip = (in_r.free_bytes == '0) || (in_r.largest_block > in_r.free_bytes);
  assign hist_any  = (cnt_r != '0);

  // min < floor(avg*4/5)  <=>  5*min + 5 <= 4*avg
  assign leak_lhs = ({3'b000, min_r} << 2) + {3'b000, min_r} + (W + 3)'(5);
  assign leak_rhs = {1'b0, avg_r, 2'b00};

  always_comb begin
    div_req = '0;
    unique case (state_r)
      S_USE: begin
        div_req.start    = go_r && !use_skip;
        div_req.iters    = hum_pkg::DIV_PCT_ITERS;
        div_req.rem_init = prod_u_r[hum_pkg::PROD_W-1:hum_pkg::PCT_W];
        div_req.low      = {prod_u_r[hum_pkg::PCT_W-1:0], (W - hum_pkg::PCT_W)'(0)};
        div_req.divisor  = in_r.total_bytes;
      end
      S_FRAG: begin
        div_req.start    = go_r && !frag_skip;
        div_req.iters    = hum_pkg::DIV_PCT_ITERS;
        div_req.rem_init = prod_f_r[hum_pkg::PROD_W-1:hum_pkg::PCT_W];
        div_req.low      = {prod_f_r[hum_pkg::PCT_W-1:0], (W - hum_pkg::PCT_W)'(0)};
        div_req.divisor  = in_r.free_bytes;
      end
      S_AVG: begin
        div_req.start    = go_r && hist_any;
        div_req.iters    = hum_pkg::DIV_AVG_ITERS;
        div_req.rem_init = W'(sum_r[SUM_W-1:W]);
        div_req.low      = sum_r[W-1:0];
        div_req.divisor  = W'(cnt_r);
      end
      default: div_req = '0;
    endcase
  end

  hum_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r   <= in_data;
            sum_r  <= '0;
            min_r  <= '1;
            max_r  <= '0;
            scan_r <= '0;
            if (in_data.func == hum_pkg::FUNC_RECORD) begin
              if (cnt_r != CNT_W'(HISTORY_DEPTH)) begin
                cnt_r <= cnt_r + CNT_W'(1);
              end
            end else if (in_data.func == hum_pkg::FUNC_CLEAR) begin
              cnt_r <= '0;
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (incl) begin
            sum_r <= sum_r + SUM_W'(tail);
            if (tail < min_r) begin
              min_r <= tail;
            end
            if (tail > max_r) begin
              max_r <= tail;
            end
          end
          prod_u_r <= hum_pkg::PROD_W'(in_r.total_bytes - in_r.free_bytes) * hum_pkg::PCT_SCALE;
          prod_f_r <= hum_pkg::PROD_W'(in_r.free_bytes - in_r.largest_block)
                      * hum_pkg::PCT_SCALE;
          if (scan_last) begin
            state_r <= S_USE;
            go_r    <= 1'b1;
          end else begin
            scan_r <= scan_r + CNT_W'(1);
          end
        end
        S_USE: begin
          if (go_r) begin
            if (use_skip) begin
              use_q_r <= '0;
              state_r <= S_FRAG;
            end else begin
              go_r <= 1'b0;
            end
          end else if (div_rsp.done) begin
            use_q_r <= div_rsp.quot[hum_pkg::PCT_W-1:0];
            state_r <= S_FRAG;
            go_r    <= 1'b1;
          end
        end
        S_FRAG: begin
          if (go_r) begin
            if (frag_skip) begin
              frag_q_r <= '0;
              state_r  <= S_AVG;
            end else begin
              go_r <= 1'b0;
            end
          end else if (div_rsp.done) begin
            frag_q_r <= div_rsp.quot[hum_pkg::PCT_W-1:0];
            state_r  <= S_AVG;
            go_r     <= 1'b1;
          end
        end
        S_AVG: begin
          if (go_r) begin
            if (!hist_any) begin
              avg_r   <= '0;
              go_r    <= 1'b0;
              state_r <= S_DONE;
            end else begin
              go_r <= 1'b0;
            end
          end else if (div_rsp.done) begin
            avg_r   <= div_rsp.quot;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_r.usage_percent <= use_q_r;
            out_r.frag_percent  <= frag_q_r;
            out_r.summary_valid <= hist_any;
            out_r.mean_free     <= avg_r;
            out_r.low_free      <= hist_any ? min_r : '0;
            out_r.peak_free     <= hist_any ? max_r : '0;
            out_r.leak_suspect  <= hist_any && (leak_lhs <= leak_rhs);
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(HISTORY_DEPTH))
    else $error("sample count above history depth");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.func == hum_pkg::FUNC_CLEAR |=> cnt_r == '0)
    else $error("clear word left samples in history");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word loaded outside done state");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.summary_valid |-> out_r.low_free <= out_r.peak_free)
    else $error("reported minimum above maximum");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int HIST_DEPTH = 32;
  localparam int ITEM_GOAL = 650;
  localparam int QUIET_TAIL = 60;
  localparam int SETTLE_CYCLES = 120;
  localparam int MAX_PRINTS = 50;

  class heap_window_scoreboard;
    logic [hum_pkg::WORD_W-1:0] samples [HIST_DEPTH];
    int unsigned wr_ptr;
    int unsigned fill_cnt;
    hum_pkg::out_t awaited [$];
    int unsigned mismatches;
    int unsigned matched;
    int unsigned records;
    int unsigned clears;
    int unsigned reports;
    int unsigned wraps;
    int unsigned leaks;

    function new();
      wr_ptr = 0;
      fill_cnt = 0;
      mismatches = 0;
      matched = 0;
      records = 0;
      clears = 0;
      reports = 0;
      wraps = 0;
      leaks = 0;
    endfunction

    task report(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) begin
        $display("%0t ns: mismatch: %s", $time, msg);
      end
    endtask

    // update the window, then work out what the block should answer
    function hum_pkg::out_t window_result(hum_pkg::in_t w);
      hum_pkg::out_t r;
      logic [63:0] acc;
      logic [63:0] num;
      logic [63:0] den;
      logic [hum_pkg::WORD_W-1:0] lo;
      logic [hum_pkg::WORD_W-1:0] hi;
      int unsigned k;
      r = '0;
      case (w.func)
        hum_pkg::FUNC_RECORD: begin
          if (fill_cnt == HIST_DEPTH) wraps++;
          samples[wr_ptr] = w.free_bytes;
          wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
          if (fill_cnt < HIST_DEPTH) fill_cnt++;
          records++;
        end
        hum_pkg::FUNC_CLEAR: begin
          wr_ptr = 0;
          fill_cnt = 0;
          clears++;
        end
        default: begin
          reports++;
        end
      endcase
      if (w.total_bytes != '0 && w.free_bytes <= w.total_bytes) begin
        num = {32'd0, w.total_bytes - w.free_bytes} * 64'd100;
        den = {32'd0, w.total_bytes};
        r.usage_percent = hum_pkg::PCT_W'(num / den);
      end
      if (w.free_bytes != '0 && w.largest_block <= w.free_bytes) begin
        num = {32'd0, w.free_bytes - w.largest_block} * 64'd100;
        den = {32'd0, w.free_bytes};
        r.frag_percent = hum_pkg::PCT_W'(num / den);
      end
      if (fill_cnt > 0) begin
        acc = '0;
        lo = '1;
        hi = '0;
        for (k = 0; k < fill_cnt; k++) begin
          acc = acc + {32'd0, samples[k]};
          if (samples[k] < lo) lo = samples[k];
          if (samples[k] > hi) hi = samples[k];
        end
        r.summary_valid = 1'b1;
        r.mean_free = hum_pkg::WORD_W'(acc / 64'(fill_cnt));
        r.low_free = lo;
        r.peak_free = hi;
        r.leak_suspect = {32'd0, lo} < ({32'd0, r.mean_free} * 64'd80) / 64'd100;
      end
      return r;
    endfunction

    function void note_input(hum_pkg::in_t w);
      hum_pkg::out_t r;
      r = window_result(w);
      if (r.leak_suspect) leaks++;
      awaited.push_back(r);
    endfunction

    task check_result(input hum_pkg::out_t got);
      hum_pkg::out_t exp;
      if (awaited.size() == 0) begin
        report("result word with nothing pending");
      end else begin
        exp = awaited.pop_front();
        if (got.usage_percent !== exp.usage_percent)
          report($sformatf("usage_percent got %0d exp %0d", got.usage_percent,
                           exp.usage_percent));
        if (got.frag_percent !== exp.frag_percent)
          report($sformatf("frag_percent got %0d exp %0d", got.frag_percent,
                           exp.frag_percent));
        if (got.summary_valid !== exp.summary_valid)
          report($sformatf("summary_valid got %0b exp %0b", got.summary_valid,
                           exp.summary_valid));
        if (got.mean_free !== exp.mean_free)
          report($sformatf("mean_free got %0h exp %0h", got.mean_free, exp.mean_free));
        if (got.low_free !== exp.low_free)
          report($sformatf("low_free got %0h exp %0h", got.low_free, exp.low_free));
        if (got.peak_free !== exp.peak_free)
          report($sformatf("peak_free got %0h exp %0h", got.peak_free, exp.peak_free));
        if (got.leak_suspect !== exp.leak_suspect)
          report($sformatf("leak_suspect got %0b exp %0b", got.leak_suspect,
                           exp.leak_suspect));
        matched++;
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hum_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hum_pkg::out_t out_data;

  heap_window_scoreboard sb;
  bit quiet = 1'b0;
  bit calm = 1'b0;
  int unsigned sent = 0;
  int unsigned stall_left = 0;

  heap_usage_window_monitor_top #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver side: random stall bursts unless quiet or calm
  always @(posedge clk) begin
    if (quiet || calm) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  task send_word(input hum_pkg::in_t w);
    int unsigned gap;
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    sent++;
  endtask

  // free bytes cluster around a baseline, with dips and extremes
  function automatic hum_pkg::in_t make_sample(logic [1:0] f,
                                               logic [hum_pkg::WORD_W-1:0] base);
    hum_pkg::in_t w;
    w.func = f;
    case ($urandom_range(0, 9))
      0: w.free_bytes = '0;
      1: w.free_bytes = '1;
      2, 3: w.free_bytes = $urandom;
      4: w.free_bytes = base >> 2;
      default: w.free_bytes = base - (base >> 4) + ($urandom % ((base >> 3) + 1));
    endcase
    case ($urandom_range(0, 7))
      0: w.total_bytes = '0;
      1: w.total_bytes = '1;
      2: w.total_bytes = w.free_bytes;
      3: w.total_bytes = $urandom;
      4: w.total_bytes = w.free_bytes - 1;
      default: w.total_bytes = w.free_bytes + $urandom_range(0, ~w.free_bytes);
    endcase
    case ($urandom_range(0, 6))
      0: w.largest_block = '0;
      1: w.largest_block = '1;
      2: w.largest_block = w.free_bytes;
      3: w.largest_block = $urandom;
      4: w.largest_block = w.free_bytes + 1;
      default: w.largest_block = $urandom_range(0, w.free_bytes);
    endcase
    return w;
  endfunction

  function automatic logic [1:0] pick_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return hum_pkg::FUNC_RECORD;
    if (r < 92) return hum_pkg::FUNC_REPORT;
    if (r < 96) return hum_pkg::FUNC_SPARE;
    return hum_pkg::FUNC_CLEAR;
  endfunction

  initial begin
    logic [hum_pkg::WORD_W-1:0] base;
    int unsigned n;
    int unsigned k;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty window, zero and full-scale fields, every operation
    send_word('{hum_pkg::FUNC_REPORT, 32'd0, 32'd0, 32'd0});
    send_word('{hum_pkg::FUNC_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_word('{hum_pkg::FUNC_RECORD, 32'd1000, 32'd4000, 32'd250});
    send_word('{hum_pkg::FUNC_RECORD, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_word('{hum_pkg::FUNC_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0});
    send_word('{hum_pkg::FUNC_REPORT, 32'd5000, 32'd0, 32'd6000});
    send_word('{hum_pkg::FUNC_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1});
    send_word('{hum_pkg::FUNC_SPARE, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h5555_5555});
    send_word('{hum_pkg::FUNC_CLEAR, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
    send_word('{hum_pkg::FUNC_REPORT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    // steady window, then one dip raises the leak flag
    for (k = 0; k < 8; k++) begin
      send_word('{hum_pkg::FUNC_RECORD, 32'd100000, 32'd400000 + k, 32'd100000 - k});
    end
    send_word('{hum_pkg::FUNC_RECORD, 32'd1, 32'd2, 32'd0});
    send_word('{hum_pkg::FUNC_REPORT, 32'd7, 32'd7, 32'd7});
    send_word('{hum_pkg::FUNC_CLEAR, 32'd0, 32'd0, 32'd0});

    // random: mostly record runs long enough to fill and wrap the window
    while (sent < ITEM_GOAL) begin
      quiet = (sent + QUIET_TAIL >= ITEM_GOAL);
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: base = $urandom;
        1: base = $urandom_range(0, 65535);
        default: base = $urandom_range(32'h0100_0000, 32'hF000_0000);
      endcase
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          send_word(hum_pkg::in_t'({2'($urandom), $urandom, $urandom, $urandom}));
        end
      end else begin
        if ($urandom_range(0, 1) == 0) send_word(make_sample(hum_pkg::FUNC_CLEAR, base));
        n = $urandom_range(1, 45);
        for (k = 0; k < n; k++) send_word(make_sample(pick_func(), base));
      end
    end
    in_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d records, %0d clears, %0d reports; %0d results checked",
             sent, sb.records, sb.clears, sb.reports, sb.matched);
    $display("window wrapped %0d times, leak flag expected %0d times, %0d mismatches",
             sb.wraps, sb.leaks, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results pending", sb.awaited.size());
    $display("tb failed");
    $finish;
  end

endmodule
